[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/ufqu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ufqu_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic valid;
    logic same_set;
    logic index_error;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/union_find_quick_union_core.sv]
// Quick-union disjoint-set core over a 1024-entry parent table held in a
// single-port-read, single-port-write synchronous RAM. After reset the core
// writes each entry to its own index and keeps in_ready low; configuration
// writes are taken during that time. Each item then walks the parent chain
// of elem_a and then of elem_b, one RAM read per link; an item with an
// out-of-range index skips the walk and returns an index error. There is no
// path compression, so a parent chain can grow to span every element. The
// result sits in an output register, so the next item is accepted while the
// previous result waits on out_ready.
`timescale 1ns / 1ps
`default_nettype none

module union_find_quick_union_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ufqu_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic [ufqu_pkg::IDX_W-1:0] in_elem_a,
  input  wire logic [ufqu_pkg::IDX_W-1:0] in_elem_b,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_same_set,
  output logic                            out_index_error
);

  localparam logic [ufqu_pkg::CNT_W-1:0] MAX_CNT = ufqu_pkg::CNT_W'(ufqu_pkg::MAX_ELEMENTS);

  logic [ufqu_pkg::CNT_W-1:0] elem_cnt_r;
  logic [ufqu_pkg::CNT_W-1:0] limit;
  ufqu_pkg::ram_req_t         ram_req;
  logic [ufqu_pkg::IDX_W-1:0] ram_rdata;
  ufqu_pkg::res_t             res;
  logic                       res_ready;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_same_set_r;
  logic                       out_index_error_r;

  assign limit = (elem_cnt_r > MAX_CNT) ? MAX_CNT : elem_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= MAX_CNT;
    end else if (cfg_wr_en) begin
      elem_cnt_r <= cfg_wr_data;
    end
  end

  ufqu_parent_ram #(
    .DEPTH (ufqu_pkg::MAX_ELEMENTS),
    .WIDTH (ufqu_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata)
  );

  ufqu_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_elem_a (in_elem_a),
    .in_elem_b (in_elem_b),
    .limit     (limit),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_same_set_r    <= res.same_set;
      out_index_error_r <= res.index_error;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_same_set    = out_same_set_r;
  assign out_index_error = out_index_error_r;

endmodule

`default_nettype wire

[hw/rtl/ufqu_parent_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ufqu_parent_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ufqu_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ufqu_walker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic [ufqu_pkg::IDX_W-1:0]    in_elem_a,
  input  wire logic [ufqu_pkg::IDX_W-1:0]    in_elem_b,
  input  wire logic [ufqu_pkg::CNT_W-1:0]    limit,
  output ufqu_pkg::ram_req_t                 ram_req,
  input  wire logic [ufqu_pkg::IDX_W-1:0]    ram_rdata,
  output ufqu_pkg::res_t                     res,
  input  wire logic                          res_ready
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WALK_A = 3'd2;
  localparam logic [2:0] ST_WALK_B = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [ufqu_pkg::IDX_W-1:0] LAST_IDX =
    ufqu_pkg::IDX_W'(ufqu_pkg::MAX_ELEMENTS - 1);

  logic [2:0]                 state_r,  state_nxt;
  logic [ufqu_pkg::IDX_W-1:0] cnt_r,    cnt_nxt;
  logic                       action_r, action_nxt;
  logic [ufqu_pkg::IDX_W-1:0] b_r,      b_nxt;
  logic [ufqu_pkg::IDX_W-1:0] cur_r,    cur_nxt;
  logic [ufqu_pkg::IDX_W-1:0] ra_r,     ra_nxt;
  logic                       same_r,   same_nxt;
  logic                       err_r,    err_nxt;
  logic                       root_hit;
  logic                       bad_idx;

  assign root_hit = (ram_rdata == cur_r);
  assign bad_idx  = ({1'b0, in_elem_a} >= limit) || ({1'b0, in_elem_b} >= limit);

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    action_nxt      = action_r;
    b_nxt           = b_r;
    cur_nxt         = cur_r;
    ra_nxt          = ra_r;
    same_nxt        = same_r;
    err_nxt         = err_r;
    ram_req         = '0;
    in_ready        = 1'b0;
    res.valid       = 1'b0;
    res.same_set    = same_r;
    res.index_error = err_r;
    case (state_r)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt_r;
        ram_req.wdata = cnt_r;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          action_nxt = in_action;
          b_nxt      = in_elem_b;
          cur_nxt    = in_elem_a;
          if (bad_idx) begin
            err_nxt   = 1'b1;
            same_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            err_nxt       = 1'b0;
            ram_req.re    = 1'b1;
            ram_req.raddr = in_elem_a;
            state_nxt     = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        ram_req.re = 1'b1;
        if (root_hit) begin
          ra_nxt        = cur_r;
          cur_nxt       = b_r;
          ram_req.raddr = b_r;
          state_nxt     = ST_WALK_B;
        end else begin
          cur_nxt       = ram_rdata;
          ram_req.raddr = ram_rdata;
        end
      end
      ST_WALK_B: begin
        if (root_hit) begin
          same_nxt  = (cur_r == ra_r);
          state_nxt = ST_DONE;
          if (!action_r && (cur_r != ra_r)) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cur_r;
            ram_req.wdata = ra_r;
          end
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ram_rdata;
          cur_nxt       = ram_rdata;
        end
      end
      ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    ra_r     <= ra_nxt;
    same_r   <= same_nxt;
    err_r    <= err_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/ufqu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ufqu_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_same_set,
  input wire logic out_index_error
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_same_set) && $stable(out_index_error))
  `ASSERT_IMP(a_err_not_same, clk, rst_n, out_valid && out_index_error, !out_same_set)
  `ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_acc, !in_ready)
  `ASSERT_IMP(a_result_after_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind union_find_quick_union_core ufqu_checker u_ufqu_checker (.*);

`default_nettype wire
